>>> hdl/pczb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pczb_pkg: shared types and constants of the point splatter
// Frame geometry, clip planes, derived widths and the control/status bundles.
// ----------------------------------------------------------------------------
package pczb_pkg;

  localparam int FRAME_WIDTH     = 640;
  localparam int FRAME_HEIGHT    = 480;
  localparam int NEAR_CLIP       = 6554;
  localparam int FAR_CLIP        = 655360;
  localparam int CAMERA_Z_OFFSET = -131072;

  localparam int STORE_SIZE  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW          = $clog2(STORE_SIZE);
  localparam int MAX_DIM     = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int QW          = $clog2(MAX_DIM);
  localparam int DW          = $clog2(FAR_CLIP);
  localparam int SUM_W       = DW + 17;
  localparam int NUM_W       = DW + 17 + QW;
  localparam int DEPTH_W     = 32;
  localparam int PX_W        = 10;
  localparam int PY_W        = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PIPE_STAGES = 6;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_YAW, REG_SIN_YAW, REG_COS_PITCH, REG_SIN_PITCH,
    REG_PAN_X, REG_PAN_Y, REG_FOCAL_X, REG_FOCAL_Y
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_pitch;
    logic signed [31:0] pan_x;
    logic signed [31:0] pan_y;
    logic [23:0]        focal_x;
    logic [23:0]        focal_y;
  } cfg_t;

  typedef struct packed {
    logic          load;
    logic          div_start;
    logic          div_step;
    logic          rd_en;
    logic          commit;
    logic          clr_we;
    logic [AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic proj_ok;
    logic nearer;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/pczb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pczb_ctrl: sequencer of the point splatter
// Steps one item through projection, divide, depth read and commit; sweeps
// the depth store after reset and on a new frame.
// ----------------------------------------------------------------------------
module pczb_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire              operation,
  output logic             out_valid,
  input  wire              out_stall,
  output pczb_pkg::cmd_t   cmd,
  input  pczb_pkg::sts_t   sts
);
  import pczb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WAIT, S_CHECK, S_DIV, S_READ, S_TEST
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.clr_we    = (state == S_CLEAR);
    cmd.clr_addr  = cnt;
    cmd.div_start = (state == S_CHECK) && sts.proj_ok;
    cmd.div_step  = (state == S_DIV);
    cmd.rd_en     = (state == S_READ);
    cmd.commit    = (state == S_TEST) && sts.nearer && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.commit || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          if (cnt == AW'(STORE_SIZE - 1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= (operation == OP_FRAME) ? S_CLEAR : S_WAIT;
          end
        end
        S_WAIT: begin
          if (cnt == AW'(PIPE_STAGES - 1)) begin
            state <= S_CHECK;
          end
          cnt <= cnt + 1'b1;
        end
        S_CHECK: begin
          cnt   <= '0;
          state <= sts.proj_ok ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (cnt == AW'(QW - 1)) begin
            state <= S_READ;
          end
          cnt <= cnt + 1'b1;
        end
        S_READ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (!sts.nearer || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/pczb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pczb_dp: datapath of the point splatter
// Rotation and projection stages, shared restoring divider, depth store.
// ----------------------------------------------------------------------------
module pczb_dp (
  input  wire                   clk,
  input  pczb_pkg::cmd_t        cmd,
  output pczb_pkg::sts_t        sts,
  input  pczb_pkg::cfg_t        cfg,
  input  wire signed [31:0]     point_x,
  input  wire signed [31:0]     point_y,
  input  wire signed [31:0]     point_z,
  input  wire [7:0]             in_red,
  input  wire [7:0]             in_green,
  input  wire [7:0]             in_blue,
  output logic [pczb_pkg::PX_W-1:0] pixel_x,
  output logic [pczb_pkg::PY_W-1:0] pixel_y,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue
);
  import pczb_pkg::*;

  logic signed [31:0] px_r, py_r, pz_r;
  logic [7:0]         red_r, green_r, blue_r;
  logic signed [47:0] m_cx, m_sz, m_cz, m_sx, m_cpy, m_spy;
  logic signed [50:0] m_spz, m_cpz;
  logic signed [48:0] yaw_x, yaw_z;
  logic signed [51:0] pit_y, pit_z;
  logic signed [35:0] xv;
  logic signed [34:0] z1;
  logic signed [38:0] yv;
  logic signed [39:0] d_r;
  logic               near_ok, proj_ok;
  logic signed [60:0] nxs;
  logic signed [63:0] nys, nx64, big_s;
  logic [DW-1:0]      dn;
  logic [SUM_W-1:0]   sum_x, sum_y;
  logic [NUM_W-1:0]   numx, numy, den, remx, remy, dsh;
  logic [QW-1:0]      qx, qy;
  logic               gex, gey;
  logic [AW-1:0]      idx, wr_addr;
  logic [DEPTH_W-1:0] wr_data, rdata;
  logic               we;
  logic [DEPTH_W-1:0] depth_mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= point_x;
      py_r    <= point_y;
      pz_r    <= point_z;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
  end

  // yaw products, then yaw sums with floor shift
  assign yaw_x = 49'(m_cx) + 49'(m_sz);
  assign yaw_z = 49'(m_cz) - 49'(m_sx);
  // pitch sums
  assign pit_y = 52'(m_cpy) - 52'(m_spz);
  assign pit_z = 52'(m_spy) + 52'(m_cpz);

  assign nx64  = 64'(nxs);
  assign big_s = $signed(64'({dn, 16'b0}));
  assign sum_x = SUM_W'(nx64 + big_s);
  assign sum_y = SUM_W'(big_s - nys);

  always_ff @(posedge clk) begin
    m_cx    <= cfg.cos_yaw * px_r;
    m_sz    <= cfg.sin_yaw * pz_r;
    m_cz    <= cfg.cos_yaw * pz_r;
    m_sx    <= cfg.sin_yaw * px_r;
    xv      <= 36'(35'(yaw_x >>> 14)) + 36'(cfg.pan_x);
    z1      <= 35'(yaw_z >>> 14);
    m_cpy   <= cfg.cos_pitch * py_r;
    m_spy   <= cfg.sin_pitch * py_r;
    m_spz   <= cfg.sin_pitch * z1;
    m_cpz   <= cfg.cos_pitch * z1;
    yv      <= 39'(38'(pit_y >>> 14)) + 39'(cfg.pan_y);
    d_r     <= -(40'(39'(38'(pit_z >>> 14)) + 39'(CAMERA_Z_OFFSET)));
    near_ok <= (d_r > 40'(NEAR_CLIP)) && (d_r < 40'(FAR_CLIP));
    nxs     <= xv * $signed({1'b0, cfg.focal_x});
    nys     <= yv * $signed({1'b0, cfg.focal_y});
    dn      <= d_r[DW-1:0];
    proj_ok <= near_ok && (nx64 <= big_s) && (nx64 >= -big_s)
               && (nys <= big_s) && (nys >= -big_s);
    numx    <= NUM_W'(sum_x) * NUM_W'(FRAME_WIDTH - 1);
    numy    <= NUM_W'(sum_y) * NUM_W'(FRAME_HEIGHT - 1);
    den     <= NUM_W'({dn, 17'b0});
  end

  // restoring divide, one quotient bit per step on both axes
  assign gex = (remx >= dsh);
  assign gey = (remy >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      remx <= numx;
      remy <= numy;
      dsh  <= den << (QW - 1);
      qx   <= '0;
      qy   <= '0;
    end else if (cmd.div_step) begin
      remx <= gex ? remx - dsh : remx;
      remy <= gey ? remy - dsh : remy;
      qx   <= QW'({qx, gex});
      qy   <= QW'({qy, gey});
      dsh  <= dsh >> 1;
    end
  end

  assign idx     = AW'(qy) * AW'(FRAME_WIDTH) + AW'(qx);
  assign we      = cmd.clr_we || cmd.commit;
  assign wr_addr = cmd.clr_we ? cmd.clr_addr : idx;
  assign wr_data = cmd.clr_we ? '1 : DEPTH_W'(dn);

  always_ff @(posedge clk) begin
    if (we) begin
      depth_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= depth_mem[idx];
    end
  end

  assign sts.proj_ok = proj_ok;
  assign sts.nearer  = (DEPTH_W'(dn) < rdata);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pixel_x   <= PX_W'(qx);
      pixel_y   <= PY_W'(qy);
      out_red   <= red_r;
      out_green <= green_r;
      out_blue  <= blue_r;
    end
  end

endmodule
`default_nettype wire

>>> hdl/point_cloud_zbuffer_splatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_cloud_zbuffer_splatter: perspective point projection with z-buffer
// Rotates, offsets, clips and projects coloured points; emits a pixel beat
// only where the point is strictly nearer than the stored depth.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A point beat passes through capture,
// the six rotation and projection stages, a clip check, one step per
// quotient bit of the shared divider (10 at a 640x480 frame), a depth read
// and a compare-and-commit. A clipped point returns to idle after the clip
// check. A new-frame beat, and reset, start a clearing pass over the depth
// store of one entry per cycle (307200 entries at 640x480), during which no
// beat is taken; configuration writes are taken at any time. A finished
// pixel waits in the output register, so the next point may enter while it
// is still stalled.
// ----------------------------------------------------------------------------
module point_cloud_zbuffer_splatter (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write,
  input  wire [pczb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [pczb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   operation,
  input  wire signed [31:0]                     point_x,
  input  wire signed [31:0]                     point_y,
  input  wire signed [31:0]                     point_z,
  input  wire [7:0]                             in_red,
  input  wire [7:0]                             in_green,
  input  wire [7:0]                             in_blue,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [pczb_pkg::PX_W-1:0]             pixel_x,
  output logic [pczb_pkg::PY_W-1:0]             pixel_y,
  output logic [7:0]                            out_red,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_blue
);
  import pczb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers: hold reset values until written
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_yaw   <= 16'sd16384;
      cfg.sin_yaw   <= '0;
      cfg.cos_pitch <= 16'sd16384;
      cfg.sin_pitch <= '0;
      cfg.pan_x     <= '0;
      cfg.pan_y     <= '0;
      cfg.focal_x   <= 24'd65536;
      cfg.focal_y   <= 24'd65536;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS_YAW:   cfg.cos_yaw   <= cfg_data[15:0];
        REG_SIN_YAW:   cfg.sin_yaw   <= cfg_data[15:0];
        REG_COS_PITCH: cfg.cos_pitch <= cfg_data[15:0];
        REG_SIN_PITCH: cfg.sin_pitch <= cfg_data[15:0];
        REG_PAN_X:     cfg.pan_x     <= cfg_data;
        REG_PAN_Y:     cfg.pan_y     <= cfg_data;
        REG_FOCAL_X:   cfg.focal_x   <= cfg_data[23:0];
        REG_FOCAL_Y:   cfg.focal_y   <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: decides when each stage of the datapath advances
  pczb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic, divider, depth store and output register
  pczb_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

`ifndef SYNTHESIS
  // reset always starts a clearing pass, so intake is closed afterwards
  a_reset_clears: assert property (@(posedge clk) rst |=> in_stall)
    else $error("intake open straight after reset");

  // one item at a time: an accepted beat closes intake
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat taken while previous item in flight");

  // a new frame holds intake closed for the sweep
  a_frame_sweep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_FRAME) |=> ##1 in_stall)
    else $error("intake reopened during depth clear");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for point_cloud_zbuffer_splatter
// Drives point and new-frame beats under random valid/stall gaps, keeps its
// own depth store and projection arithmetic, and compares every pixel beat
// field by field against the oldest predicted write.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pczb_pkg::*;

  localparam longint RUN_LIMIT   = 4000000;
  localparam int     SETTLE_WAIT = 40;   // clipped points leave no beat; let them retire

  typedef struct {
    logic [PX_W-1:0] col;
    logic [PY_W-1:0] row;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  operation = OP_POINT;
  logic signed [31:0]    point_x = '0, point_y = '0, point_z = '0;
  logic [7:0]            in_red = '0, in_green = '0, in_blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PX_W-1:0]       pixel_x;
  logic [PY_W-1:0]       pixel_y;
  logic [7:0]            out_red, out_green, out_blue;

  point_cloud_zbuffer_splatter DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .operation, .point_x, .point_y, .point_z,
    .in_red, .in_green, .in_blue,
    .out_valid, .out_stall, .pixel_x, .pixel_y, .out_red, .out_green, .out_blue
  );

  always #5 clk = ~clk;

  // Shadow view registers, held wide for the arithmetic
  longint view_cy, view_sy, view_cp, view_sp, view_pan_x, view_pan_y;
  longint view_fx, view_fy;
  bit [31:0] shadow_depth [STORE_SIZE];

  pixel_write_t pending_writes[$];
  int  error_count = 0;
  bit  gaps_on = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;
  longint cycle_count = 0;

  function automatic void clear_shadow_depth();
    foreach (shadow_depth[i]) shadow_depth[i] = '1;
  endfunction

  // Project one point; returns 1 and fills the write when a pixel is emitted
  function automatic bit project_point(input logic signed [31:0] wx, wy, wz,
                                       input logic [7:0] r, g, b,
                                       output pixel_write_t w);
    longint x, y, z, x1, z1, xv, yv, zv, d, big, nxs, nys, col, row, idx;
    x = wx; y = wy; z = wz;
    w = '{default: '0};
    x1 = (view_cy * x + view_sy * z) >>> 14;
    z1 = (view_cy * z - view_sy * x) >>> 14;
    xv = x1 + view_pan_x;
    yv = ((view_cp * y - view_sp * z1) >>> 14) + view_pan_y;
    zv = ((view_sp * y + view_cp * z1) >>> 14) + CAMERA_Z_OFFSET;
    d  = -zv;
    if (d <= NEAR_CLIP || d >= FAR_CLIP) return 1'b0;
    big = d * 65536;
    nxs = xv * view_fx;
    nys = yv * view_fy;
    if ((nxs < 0 ? -nxs : nxs) > big || (nys < 0 ? -nys : nys) > big) return 1'b0;
    col = ((nxs + big) * (FRAME_WIDTH - 1)) / (2 * big);
    row = ((big - nys) * (FRAME_HEIGHT - 1)) / (2 * big);
    if (col < 0 || col >= FRAME_WIDTH || row < 0 || row >= FRAME_HEIGHT) return 1'b0;
    idx = row * FRAME_WIDTH + col;
    if (d >= longint'(shadow_depth[idx])) return 1'b0;
    shadow_depth[idx] = d[31:0];
    w.col = col[PX_W-1:0];
    w.row = row[PY_W-1:0];
    w.red = r; w.green = g; w.blue = b;
    return 1'b1;
  endfunction

  // Send one beat and update the prediction when it is taken
  task automatic send_beat(input logic op, input logic signed [31:0] x, y, z,
                           input logic [7:0] r, g, b);
    pixel_write_t w;
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    point_x <= x; point_y <= y; point_z <= z;
    in_red <= r; in_green <= g; in_blue <= b;
    do @(posedge clk); while (in_stall);
    if (op == OP_FRAME) clear_shadow_depth();
    else if (project_point(x, y, z, r, g, b, w)) pending_writes.push_back(w);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic send_point(input logic signed [31:0] x, y, z);
    send_beat(OP_POINT, x, y, z, 8'($urandom), 8'($urandom), 8'($urandom));
    sender_gap();
  endtask

  // Point that mostly lands in the view under near-identity settings
  task automatic send_random_point();
    int d, span;
    if ($urandom_range(0, 9) == 0) begin
      send_beat($urandom_range(0, 49) == 0 ? OP_FRAME : OP_POINT,
                $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
      sender_gap();
    end else begin
      d = $urandom_range(6000, 656000);
      span = d + d / 8;
      send_point($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                 131072 - d);
    end
  endtask

  // Drop valid and wait until every predicted write has come out and the
  // block is back at idle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Write all eight view registers; call only when the block is idle
  task automatic set_view(input logic signed [15:0] cy, sy, cp, sp,
                          input logic signed [31:0] pan_x, pan_y,
                          input logic [23:0] fx, fy);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_COS_YAW]   = {{16{cy[15]}}, cy};
    vals[REG_SIN_YAW]   = {{16{sy[15]}}, sy};
    vals[REG_COS_PITCH] = {{16{cp[15]}}, cp};
    vals[REG_SIN_PITCH] = {{16{sp[15]}}, sp};
    vals[REG_PAN_X]     = pan_x;
    vals[REG_PAN_Y]     = pan_y;
    vals[REG_FOCAL_X]   = {8'h00, fx};
    vals[REG_FOCAL_Y]   = {8'h00, fy};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    view_cy = cy; view_sy = sy; view_cp = cp; view_sp = sp;
    view_pan_x = pan_x; view_pan_y = pan_y;
    view_fx = fx; view_fy = fy;
  endtask

  // Receiver: long hold on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each pixel beat against the oldest predicted write
  always @(posedge clk) begin
    pixel_write_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected pixel beat x=%0d y=%0d", $time, pixel_x, pixel_y);
        error_count++;
      end else begin
        w = pending_writes.pop_front();
        if (pixel_x !== w.col) begin
          $display("%0t: pixel_x expected %0d got %0d", $time, w.col, pixel_x);
          error_count++;
        end
        if (pixel_y !== w.row) begin
          $display("%0t: pixel_y expected %0d got %0d", $time, w.row, pixel_y);
          error_count++;
        end
        if (out_red !== w.red) begin
          $display("%0t: out_red expected %0d got %0d", $time, w.red, out_red);
          error_count++;
        end
        if (out_green !== w.green) begin
          $display("%0t: out_green expected %0d got %0d", $time, w.green, out_green);
          error_count++;
        end
        if (out_blue !== w.blue) begin
          $display("%0t: out_blue expected %0d got %0d", $time, w.blue, out_blue);
          error_count++;
        end
      end
    end
  end

  // Watchdog; the clearing passes after reset and each new frame are long
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("point_cloud_zbuffer_splatter regression: fail");
      $finish;
    end
  end

  // Clip planes, square edges, equal depth and a new frame at default view
  task automatic test_directed();
    send_point(0, 0, 0);                       // centre
    send_point(0, 0, 0);                       // equal depth loses
    send_point(0, 0, 65536);                   // nearer wins
    send_point(131072, -131072, 0);            // bottom right corner
    send_point(-131072, 131072, 0);            // top left corner
    send_point(131073, 0, 0);                  // just outside the square
    send_point(0, 5, 131072 - NEAR_CLIP);      // on the near plane
    send_point(0, 5, 131072 - NEAR_CLIP - 1);  // just beyond it
    send_point(1000, 0, 131072 - FAR_CLIP);    // on the far plane
    send_point(1000, 0, 131072 - FAR_CLIP + 1);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_point(-1, -1, -1);
    send_beat(OP_FRAME, $urandom, $urandom, $urandom, 8'hFF, 8'hFF, 8'hFF);
    send_beat(OP_POINT, 0, 0, 0, 8'hFF, 8'h00, 8'hFF);  // cleared store accepts again
    send_beat(OP_POINT, 0, 1, 0, 8'h00, 8'hFF, 8'h00);
    drain();
  endtask

  // Extreme register settings, including zero focal factors
  task automatic test_view_extremes();
    set_view(-16384, 16384, -16384, 16384, 32'sh7FFF_FFFF, 32'sh8000_0000,
             24'hFF_FFFF, 24'hFF_FFFF);
    repeat (8) send_random_point();
    drain();
    set_view(16384, -16384, 16384, -16384, 0, 0, 24'd1, 24'd1);
    repeat (10) send_random_point();
    drain();
    set_view(16384, 0, 16384, 0, 0, 0, 24'd0, 24'd0);
    send_point(12345, -777, 30000);            // lands on the centre lines
    repeat (6) send_random_point();
    drain();
  endtask

  // Receiver holds off while points keep coming, so the input backs up
  task automatic test_backpressure();
    set_view(16384, 0, 16384, 0, 0, 0, 24'd65536, 24'd65536);
    @(negedge clk);
    hold_request = 1'b1;
    repeat (40) send_random_point();
    drain();
  endtask

  // Random points over a sweep of views; the last one runs without gaps
  task automatic test_random_views();
    logic signed [15:0] cy_tab [6] = '{16384, 15137, 11585, 16384, 15910, -16384};
    logic signed [15:0] sy_tab [6] = '{0, 6270, 11585, -2000, -3914, 0};
    for (int s = 0; s < 6; s++) begin
      set_view(cy_tab[s], sy_tab[s], cy_tab[(s + 2) % 6], sy_tab[(s + 3) % 6],
               $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
               24'($urandom_range(20000, 200000)), 24'($urandom_range(20000, 200000)));
      gaps_on = (s != 5);
      repeat (170) send_random_point();
      drain();                                 // pause until every write is out
    end
  endtask

  initial begin
    view_cy = 16384; view_sy = 0; view_cp = 16384; view_sp = 0;
    view_pan_x = 0; view_pan_y = 0; view_fx = 65536; view_fy = 65536;
    clear_shadow_depth();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    test_directed();
    test_view_extremes();
    test_backpressure();
    test_random_views();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0 && pending_writes.size() == 0) begin
      $display("point_cloud_zbuffer_splatter regression: pass");
    end else begin
      $display("point_cloud_zbuffer_splatter regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pczb_pkg.sv
hdl/pczb_ctrl.sv
hdl/pczb_dp.sv
hdl/point_cloud_zbuffer_splatter.sv
test/tb_top.sv
